// ===== design/cbqc_pkg.sv =====
package cbqc_pkg;

    // Stack of expected closing brackets.
    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    // Widths fixed by the result item.
    localparam int LINE_W        = 24;
    localparam int COLUMN_W      = 16;
    localparam int OPEN_DEPTH_W  = 7;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 64;

    // Two-bit code of an expected closing bracket.
    typedef logic [1:0] close_code_t;
    localparam close_code_t CLOSE_PAREN   = 2'd0;
    localparam close_code_t CLOSE_BRACKET = 2'd1;
    localparam close_code_t CLOSE_BRACE   = 2'd2;

    // Source bytes of interest.
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;

    // Error codes reported per item.
    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_UNEXPECTED    = 3'd1,
        ERR_MISMATCH      = 3'd2,
        ERR_OPEN_QUOTE    = 3'd3,
        ERR_OPEN_COMMENT  = 3'd4,
        ERR_OPEN_BRACKETS = 3'd5,
        ERR_OVERFLOW      = 3'd6
    } err_code_t;

    // Push and pop commands from the scanner to the row of stack cells.
    typedef struct packed {
        logic        push;
        logic        pop;
        close_code_t code;
    } stack_ctrl_t;

    // One result item without its last flag, error code in the lowest bits.
    typedef struct packed {
        logic                    syntax_ok;
        logic [OPEN_DEPTH_W-1:0] open_depth;
        logic [COLUMN_W-1:0]     column_number;
        logic [LINE_W-1:0]       line_number;
        logic [7:0]              expected_close;
        err_code_t               error_code;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ===== design/cbqc_stack_cell.sv =====
module cbqc_stack_cell (
    input  logic                 aclk,
    input  cbqc_pkg::stack_ctrl_t ctrl,
    input  cbqc_pkg::close_code_t above_code,
    input  cbqc_pkg::close_code_t below_code,
    output cbqc_pkg::close_code_t code
);
    import cbqc_pkg::*;

    close_code_t code_reg;

    // A push moves the entry one place deeper, a pop brings the deeper one up.
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            code_reg <= above_code;
        end else if (ctrl.pop) begin
            code_reg <= below_code;
        end
    end

    assign code = code_reg;

endmodule

// ===== design/cbqc_scanner.sv =====
module cbqc_scanner (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            char_in,
    input  logic                  is_last,
    input  cbqc_pkg::close_code_t top_code,
    input  cbqc_pkg::close_code_t next_code,
    output cbqc_pkg::stack_ctrl_t stack_ctrl,
    output cbqc_pkg::result_t     result
);
    import cbqc_pkg::*;

    typedef enum logic [2:0] {
        M_CODE  = 3'd0,
        M_SLASH = 3'd1,
        M_LINE  = 3'd2,
        M_BLOCK = 3'd3,
        M_STAR  = 3'd4,
        M_QUOTE = 3'd5,
        M_ESC   = 3'd6
    } mode_t;

    localparam logic [DEPTH_W-1:0]  DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
    localparam logic [LINE_W-1:0]   LINE_MAX   = '1;
    localparam logic [COLUMN_W-1:0] COL_MAX    = '1;

    function automatic logic [7:0] close_char(input close_code_t cc);
        logic [7:0] ch;
        case (cc)
            CLOSE_PAREN:   ch = CH_RPAREN;
            CLOSE_BRACKET: ch = CH_RBRACKET;
            CLOSE_BRACE:   ch = CH_RBRACE;
            default:       ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic close_code_t byte_to_code(input logic [7:0] ch);
        close_code_t cc;
        case (ch) inside
            CH_LPAREN, CH_RPAREN:     cc = CLOSE_PAREN;
            CH_LBRACKET, CH_RBRACKET: cc = CLOSE_BRACKET;
            default:                  cc = CLOSE_BRACE;
        endcase
        return cc;
    endfunction

    mode_t                mode_reg, mode_next;
    logic                 quote_reg, quote_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic [COLUMN_W-1:0]  col_reg, col_next, col_now;
    logic                 ok_reg, ok_next;

    err_code_t            err;
    logic [7:0]           exp_char;
    logic                 run_code, push, pop, is_nl;
    close_code_t          push_code, top_after;

    assign is_nl = (char_in == CH_NEWLINE);

    // Scanner mode step and bracket handling for one byte.
    always_comb begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        err        = ERR_NONE;
        exp_char   = 8'h00;
        run_code   = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        push_code  = byte_to_code(char_in);

        unique case (mode_reg)
            M_SLASH: begin
                if (char_in == CH_SLASH) begin
                    mode_next = M_LINE;
                end else if (char_in == CH_STAR) begin
                    mode_next = M_BLOCK;
                end else begin
                    run_code = 1'b1;
                end
            end
            M_LINE: begin
                if (is_nl) begin
                    mode_next = M_CODE;
                end
            end
            M_BLOCK: begin
                if (char_in == CH_STAR) begin
                    mode_next = M_STAR;
                end
            end
            M_STAR: begin
                if (char_in == CH_SLASH) begin
                    mode_next = M_CODE;
                end else if (char_in != CH_STAR) begin
                    mode_next = M_BLOCK;
                end
            end
            M_QUOTE: begin
                if (char_in == CH_BSLASH) begin
                    mode_next = M_ESC;
                end else if (is_nl) begin
                    mode_next = M_CODE;
                    err       = ERR_OPEN_QUOTE;
                end else if (char_in == (quote_reg ? CH_SQUOTE : CH_DQUOTE)) begin
                    mode_next = M_CODE;
                end
            end
            M_ESC: begin
                mode_next = M_QUOTE;
            end
            default: begin
                run_code = 1'b1;
            end
        endcase

        // A byte seen as plain code.
        if (run_code) begin
            mode_next = M_CODE;
            case (char_in) inside
                CH_SLASH: begin
                    mode_next = M_SLASH;
                end
                CH_DQUOTE, CH_SQUOTE: begin
                    mode_next  = M_QUOTE;
                    quote_next = (char_in == CH_SQUOTE);
                end
                CH_LPAREN, CH_LBRACKET, CH_LBRACE: begin
                    if (depth_reg >= DEPTH_FULL) begin
                        err = ERR_OVERFLOW;
                    end else begin
                        push = 1'b1;
                    end
                end
                CH_RPAREN, CH_RBRACKET, CH_RBRACE: begin
                    if (depth_reg == '0) begin
                        err = ERR_UNEXPECTED;
                    end else if (top_code == push_code) begin
                        pop = 1'b1;
                    end else begin
                        err      = ERR_MISMATCH;
                        exp_char = close_char(top_code);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Stack state after this byte.
    always_comb begin
        if (push) begin
            depth_next = depth_reg + 1'b1;
            top_after  = push_code;
        end else if (pop) begin
            depth_next = depth_reg - 1'b1;
            top_after  = next_code;
        end else begin
            depth_next = depth_reg;
            top_after  = top_code;
        end
    end

    // Line and column counters, both saturating.
    always_comb begin
        col_now   = (col_reg != COL_MAX) ? col_reg + 1'b1 : col_reg;
        col_next  = is_nl ? '0 : col_now;
        line_next = (is_nl && line_reg != LINE_MAX) ? line_reg + 1'b1 : line_reg;
    end

    // End checks on the last byte and the assembled result.
    always_comb begin
        result.error_code     = err;
        result.expected_close = exp_char;
        if (is_last) begin
            if (err == ERR_NONE && (mode_next == M_BLOCK || mode_next == M_STAR)) begin
                result.error_code = ERR_OPEN_COMMENT;
            end else if (err == ERR_NONE && depth_next != '0) begin
                result.error_code     = ERR_OPEN_BRACKETS;
                result.expected_close = close_char(top_after);
            end
        end
        ok_next              = ok_reg & (result.error_code == ERR_NONE);
        result.syntax_ok     = ok_next;
        result.open_depth    = OPEN_DEPTH_W'(depth_next);
        result.column_number = col_now;
        result.line_number   = line_reg;
    end

    assign stack_ctrl.push = push & accept;
    assign stack_ctrl.pop  = pop & accept;
    assign stack_ctrl.code = push_code;

    // Scanner state; the last byte of a file returns everything to reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_CODE;
            quote_reg <= 1'b0;
            depth_reg <= '0;
            line_reg  <= LINE_W'(1);
            col_reg   <= '0;
            ok_reg    <= 1'b1;
        end else if (accept) begin
            if (is_last) begin
                mode_reg  <= M_CODE;
                quote_reg <= 1'b0;
                depth_reg <= '0;
                line_reg  <= LINE_W'(1);
                col_reg   <= '0;
                ok_reg    <= 1'b1;
            end else begin
                mode_reg  <= mode_next;
                quote_reg <= quote_next;
                depth_reg <= depth_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
                ok_reg    <= ok_next;
            end
        end
    end

endmodule

// ===== design/c_bracket_quote_comment_checker_core.sv =====
// Output: each result item is registered in the output register, or in the skid
// entry while the output is stalled, a two-entry stage that absorbs stalls.
// Throughput: one byte per cycle while the skid entry is empty.
// Reset: synchronous, active low; mode returns to code, the stack to empty, line to
// one, column to zero and the ok flag to one. Stack cells are not cleared.
module c_bracket_quote_comment_checker_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // char_in [7:0]
    input  logic [cbqc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // error_code [2:0], expected_close [10:3], line_number [34:11],
    // column_number [50:35], open_depth [57:51], syntax_ok [58], zeros above
    output logic [cbqc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import cbqc_pkg::*;

    logic        accept;
    stack_ctrl_t stack_ctrl;
    result_t     result;
    close_code_t cell_code [STACK_DEPTH];

    result_t     out_reg, skid_reg;
    logic        out_last_reg, skid_last_reg;
    logic        out_valid_reg, skid_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    cbqc_scanner u_scanner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .char_in    (s_tdata[7:0]),
        .is_last    (s_tlast),
        .top_code   (cell_code[0]),
        .next_code  (cell_code[1]),
        .stack_ctrl (stack_ctrl),
        .result     (result)
    );

    // Row of stack cells, cell zero holding the top entry.
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        close_code_t above_code, below_code;
        if (i == 0) begin : g_head
            assign above_code = stack_ctrl.code;
        end else begin : g_body
            assign above_code = cell_code[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_tail
            assign below_code = CLOSE_PAREN;
        end else begin : g_inner
            assign below_code = cell_code[i+1];
        end
        cbqc_stack_cell u_cell (
            .aclk       (aclk),
            .ctrl       (stack_ctrl),
            .above_code (above_code),
            .below_code (below_code),
            .code       (cell_code[i])
        );
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg        <= skid_reg;
                out_last_reg   <= skid_last_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || m_tready) begin
                out_reg       <= result;
                out_last_reg  <= s_tlast;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= result;
                skid_last_reg  <= s_tlast;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/cbqc_checker.sv =====
module cbqc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cbqc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);
    import cbqc_pkg::*;

    // No result is offered straight after reset.
    a_idle_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result offered straight after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Any error clears the ok flag on the same item.
    a_error_clears_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ERR_NONE |-> !m_tdata[58])
        else $error("error reported with ok flag set");

    // A mismatch or open brackets always names a closing byte, columns start at one.
    a_expected_named: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ERR_MISMATCH || m_tdata[2:0] == ERR_OPEN_BRACKETS)
        |-> m_tdata[10:3] != 8'h00 && m_tdata[50:35] != '0)
        else $error("closing byte or column missing");

    // Open brackets at end of input implies a non-empty stack on the last item.
    a_open_brackets_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == ERR_OPEN_BRACKETS |-> m_tlast && m_tdata[57:51] != '0)
        else $error("open brackets reported without open depth");

endmodule

bind c_bracket_quote_comment_checker_core cbqc_checker u_cbqc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_c_bracket_quote_comment_checker_core.sv =====
module tb_c_bracket_quote_comment_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cbqc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 400;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LETTER = 8'h61;

    // Scanner states of the predictor.
    typedef enum logic [2:0] {
        SC_CODE, SC_SLASH, SC_LINE, SC_BLOCK, SC_STAR, SC_QUOTE, SC_ESC
    } scan_state_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } src_byte_t;

    typedef struct packed {
        logic    last;
        result_t r;
    } verdict_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // Source bytes waiting to be sent and verdicts waiting to come back.
    src_byte_t  src_bytes[$];
    verdict_t   verdicts_due[$];
    logic [7:0] file_buf[$];
    src_byte_t  next_byte;
    int         queued_total = 0;
    int         errors = 0;
    int         cycle_count = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;

    // Predictor state.
    scan_state_t scan_state;
    logic        in_single_quote;
    close_code_t bracket_codes [STACK_DEPTH];
    int          bracket_depth;
    logic [23:0] cur_line;
    logic [15:0] cur_column;
    logic        clean_so_far;

    c_bracket_quote_comment_checker_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Back to the state of a fresh file.
    function automatic void restart_scan();
        scan_state      = SC_CODE;
        in_single_quote = 1'b0;
        bracket_depth   = 0;
        cur_line        = 24'd1;
        cur_column      = 16'd0;
        clean_so_far    = 1'b1;
    endfunction

    function automatic logic [7:0] close_char_of(input close_code_t c);
        case (c)
            CLOSE_PAREN:   return CH_RPAREN;
            CLOSE_BRACKET: return CH_RBRACKET;
            default:       return CH_RBRACE;
        endcase
    endfunction

    // Effect of one byte seen in code: quotes, comments and the bracket stack.
    function automatic void code_byte_effect(input logic [7:0] ch, output err_code_t e,
                                             output logic [7:0] x);
        close_code_t want;
        logic        is_close;
        e        = ERR_NONE;
        x        = 8'h00;
        is_close = 1'b0;
        want     = CLOSE_PAREN;
        case (ch)
            CH_SLASH: scan_state = SC_SLASH;
            CH_DQUOTE, CH_SQUOTE: begin
                scan_state      = SC_QUOTE;
                in_single_quote = (ch == CH_SQUOTE);
            end
            CH_LPAREN, CH_LBRACKET, CH_LBRACE: begin
                if (bracket_depth >= STACK_DEPTH) begin
                    e = ERR_OVERFLOW;
                end else begin
                    bracket_codes[bracket_depth] = (ch == CH_LPAREN) ? CLOSE_PAREN :
                        (ch == CH_LBRACKET) ? CLOSE_BRACKET : CLOSE_BRACE;
                    bracket_depth++;
                end
            end
            CH_RPAREN: begin
                is_close = 1'b1;
                want     = CLOSE_PAREN;
            end
            CH_RBRACKET: begin
                is_close = 1'b1;
                want     = CLOSE_BRACKET;
            end
            CH_RBRACE: begin
                is_close = 1'b1;
                want     = CLOSE_BRACE;
            end
            default: ;
        endcase
        if (is_close) begin
            if (bracket_depth == 0) begin
                e = ERR_UNEXPECTED;
            end else if (bracket_codes[bracket_depth-1] == want) begin
                bracket_depth--;
            end else begin
                e = ERR_MISMATCH;
                x = close_char_of(bracket_codes[bracket_depth-1]);
            end
        end
    endfunction

    // Verdict for one accepted byte; the state moves on as the block's does.
    function automatic verdict_t scan_byte(input logic [7:0] ch, input logic last);
        verdict_t    v;
        err_code_t   e;
        logic [7:0]  x;
        logic [23:0] line_now;
        logic [15:0] col_now;
        e = ERR_NONE;
        x = 8'h00;
        if (cur_column != 16'hFFFF) cur_column++;
        line_now = cur_line;
        col_now  = cur_column;
        case (scan_state)
            SC_SLASH: begin
                if (ch == CH_SLASH) begin
                    scan_state = SC_LINE;
                end else if (ch == CH_STAR) begin
                    scan_state = SC_BLOCK;
                end else begin
                    scan_state = SC_CODE;
                    code_byte_effect(ch, e, x);
                end
            end
            SC_LINE: if (ch == CH_NEWLINE) scan_state = SC_CODE;
            SC_BLOCK: if (ch == CH_STAR) scan_state = SC_STAR;
            SC_STAR: begin
                if (ch == CH_SLASH) scan_state = SC_CODE;
                else if (ch != CH_STAR) scan_state = SC_BLOCK;
            end
            SC_QUOTE: begin
                if (ch == CH_BSLASH) begin
                    scan_state = SC_ESC;
                end else if (ch == CH_NEWLINE) begin
                    scan_state = SC_CODE;
                    e = ERR_OPEN_QUOTE;
                end else if (ch == (in_single_quote ? CH_SQUOTE : CH_DQUOTE)) begin
                    scan_state = SC_CODE;
                end
            end
            SC_ESC: scan_state = SC_QUOTE;
            default: begin
                scan_state = SC_CODE;
                code_byte_effect(ch, e, x);
            end
        endcase
        if (ch == CH_NEWLINE) begin
            if (cur_line != 24'hFFFFFF) cur_line++;
            cur_column = 16'd0;
        end
        // End checks: an open comment first, then brackets left open.
        if (last) begin
            if (scan_state == SC_BLOCK || scan_state == SC_STAR) begin
                clean_so_far = 1'b0;
                if (e == ERR_NONE) e = ERR_OPEN_COMMENT;
            end
            if (bracket_depth > 0) begin
                clean_so_far = 1'b0;
                if (e == ERR_NONE) begin
                    e = ERR_OPEN_BRACKETS;
                    x = close_char_of(bracket_codes[bracket_depth-1]);
                end
            end
        end
        if (e != ERR_NONE) clean_so_far = 1'b0;
        v.r.error_code     = e;
        v.r.expected_close = x;
        v.r.line_number    = line_now;
        v.r.column_number  = col_now;
        v.r.open_depth     = 7'(bracket_depth);
        v.r.syntax_ok      = clean_so_far;
        v.last             = last;
        if (last) restart_scan();
        return v;
    endfunction

    // Byte generators for the source text.
    function automatic logic [7:0] letter();
        return 8'(CH_LETTER + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 11))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACKET;
            3:       return CH_RBRACKET;
            4:       return CH_LBRACE;
            5:       return CH_RBRACE;
            6:       return CH_SLASH;
            7:       return CH_STAR;
            8:       return CH_BSLASH;
            9:       return CH_NEWLINE;
            10:      return CH_DQUOTE;
            default: return CH_SQUOTE;
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
        return special_byte();
    endfunction

    function automatic logic [7:0] filler_byte(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        logic [7:0] v;
        do v = noise_byte(); while (v == a || v == b || v == c);
        return v;
    endfunction

    // Moves the file under construction to the send queue, last byte marked.
    task automatic ship_file();
        for (int i = 0; i < file_buf.size(); i++) begin
            src_bytes.push_back('{ch: file_buf[i], last: (i == file_buf.size() - 1)});
        end
        queued_total += file_buf.size();
        file_buf.delete();
    endtask

    // Mostly sound C-like text with random content, a few slips mixed in.
    task automatic add_wellformed_file();
        logic [7:0] closers[$];
        logic [7:0] q;
        int         k;
        repeat ($urandom_range(3, 20)) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3: file_buf.push_back(letter());
                4: file_buf.push_back(CH_SPACE);
                5: file_buf.push_back(CH_NEWLINE);
                6, 7: begin
                    k = $urandom_range(0, 2);
                    file_buf.push_back(k == 0 ? CH_LPAREN : k == 1 ? CH_LBRACKET : CH_LBRACE);
                    closers.push_back(k == 0 ? CH_RPAREN : k == 1 ? CH_RBRACKET : CH_RBRACE);
                end
                8: if (closers.size() != 0) file_buf.push_back(closers.pop_back());
                9: begin
                    file_buf.push_back(CH_SLASH);
                    file_buf.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 8))
                        file_buf.push_back(filler_byte(CH_NEWLINE, CH_NEWLINE, CH_NEWLINE));
                    file_buf.push_back(CH_NEWLINE);
                end
                10: begin
                    file_buf.push_back(CH_SLASH);
                    file_buf.push_back(CH_STAR);
                    repeat ($urandom_range(0, 10)) begin
                        if ($urandom_range(0, 3) == 0) file_buf.push_back(CH_STAR);
                        else file_buf.push_back(filler_byte(CH_SLASH, CH_SLASH, CH_SLASH));
                    end
                    repeat ($urandom_range(1, 3)) file_buf.push_back(CH_STAR);
                    file_buf.push_back(CH_SLASH);
                end
                11: begin
                    // String or character literal with escapes of any byte.
                    q = ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
                    file_buf.push_back(q);
                    repeat ($urandom_range(0, 8)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            file_buf.push_back(CH_BSLASH);
                            file_buf.push_back(8'($urandom_range(0, 255)));
                        end else begin
                            file_buf.push_back(filler_byte(CH_NEWLINE, CH_BSLASH, q));
                        end
                    end
                    file_buf.push_back(q);
                end
                12: begin
                    file_buf.push_back(letter());
                    file_buf.push_back(CH_SLASH);
                    file_buf.push_back(letter());
                end
                13: begin
                    // Quote left open at the end of its line.
                    file_buf.push_back(CH_DQUOTE);
                    file_buf.push_back(letter());
                    file_buf.push_back(CH_NEWLINE);
                end
                14: file_buf.push_back(noise_byte());
                default: begin
                    k = $urandom_range(0, 2);
                    file_buf.push_back(k == 0 ? CH_RPAREN : k == 1 ? CH_RBRACKET : CH_RBRACE);
                end
            endcase
        end
        if ($urandom_range(0, 3) != 0) begin
            while (closers.size() != 0) file_buf.push_back(closers.pop_back());
        end
        // Endings that leave a comment, a slash or a quote open.
        case ($urandom_range(0, 11))
            0: begin
                file_buf.push_back(CH_SLASH);
                file_buf.push_back(CH_SLASH);
                file_buf.push_back(letter());
            end
            1: begin
                file_buf.push_back(CH_SLASH);
                file_buf.push_back(CH_STAR);
                file_buf.push_back(letter());
            end
            2: file_buf.push_back(CH_SLASH);
            3: begin
                file_buf.push_back(CH_DQUOTE);
                file_buf.push_back(letter());
            end
            4: file_buf.push_back(CH_SQUOTE);
            default: ;
        endcase
        if (file_buf.size() == 0) file_buf.push_back(letter());
        ship_file();
    endtask

    // Nesting near and sometimes past the stack depth, then the matching closes.
    task automatic add_deep_file();
        logic [7:0] closers[$];
        int         k;
        repeat ($urandom_range(60, 70)) begin
            k = $urandom_range(0, 2);
            file_buf.push_back(k == 0 ? CH_LPAREN : k == 1 ? CH_LBRACKET : CH_LBRACE);
            closers.push_back(k == 0 ? CH_RPAREN : k == 1 ? CH_RBRACKET : CH_RBRACE);
        end
        file_buf.push_back(letter());
        while (closers.size() != 0) file_buf.push_back(closers.pop_back());
        ship_file();
    endtask

    task automatic add_noise_file();
        repeat ($urandom_range(1, 30)) file_buf.push_back(noise_byte());
        ship_file();
    endtask

    // Sender: an item is offered from the queue unless this cycle is a gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) verdicts_due.push_back(scan_byte(s_tdata, s_tlast));
            if (!s_tvalid || s_tready) begin
                if (src_bytes.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    next_byte = src_bytes.pop_front();
                    s_tdata   <= next_byte.ch;
                    s_tlast   <= next_byte.last;
                    s_tvalid  <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_field(input string name, input longint want, input longint got);
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
    endtask

    // Receiver: each result item is checked against the oldest verdict.
    always @(posedge aclk) begin
        result_t  got;
        verdict_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (verdicts_due.size() == 0) begin
                    $display("%0t: result item with none outstanding, expected nothing actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.error_code !== want.r.error_code)
                        flag_field("error_code", want.r.error_code, got.error_code);
                    if (got.expected_close !== want.r.expected_close)
                        flag_field("expected_close", want.r.expected_close, got.expected_close);
                    if (got.line_number !== want.r.line_number)
                        flag_field("line_number", want.r.line_number, got.line_number);
                    if (got.column_number !== want.r.column_number)
                        flag_field("column_number", want.r.column_number, got.column_number);
                    if (got.open_depth !== want.r.open_depth)
                        flag_field("open_depth", want.r.open_depth, got.open_depth);
                    if (got.syntax_ok !== want.r.syntax_ok)
                        flag_field("syntax_ok", want.r.syntax_ok, got.syntax_ok);
                    if (m_tlast !== want.last)
                        flag_field("last_out", want.last, m_tlast);
                    if (m_tdata[OUT_TDATA_W-1:RESULT_W] !== '0)
                        flag_field("padding", 0, m_tdata[OUT_TDATA_W-1:RESULT_W]);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("c_bracket_quote_comment_checker_core: mismatch");
            $finish;
        end
    end

    initial begin
        logic [7:0] opening [22];
        int         phase_end;
        restart_scan();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Short directed file: byte extremes, every bracket, mismatched and
        // unexpected closes, slash then code, an escaped newline in a character
        // literal, an open quote at a newline, an empty block comment and
        // brackets left open at the end.
        opening = '{8'h00, 8'hFF, CH_LPAREN, CH_LBRACKET, CH_RPAREN, CH_RBRACKET,
                    CH_RPAREN, CH_RBRACE, CH_SLASH, CH_LPAREN, CH_SQUOTE, CH_BSLASH,
                    CH_NEWLINE, CH_SQUOTE, CH_DQUOTE, CH_LETTER, CH_NEWLINE, CH_SLASH,
                    CH_STAR, CH_STAR, CH_SLASH, CH_LBRACE};
        foreach (opening[i]) file_buf.push_back(opening[i]);
        ship_file();
        // Block comment open at the end, then a line comment at the end.
        file_buf.push_back(CH_SLASH);
        file_buf.push_back(CH_STAR);
        ship_file();
        file_buf.push_back(CH_SLASH);
        file_buf.push_back(CH_SLASH);
        ship_file();

        for (int p = 0; p < 4; p++) begin
            @(negedge aclk);
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 84; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 84; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            phase_end = queued_total + PHASE_ITEMS;
            if (p == 0) add_deep_file();
            while (queued_total < phase_end) begin
                case ($urandom_range(0, 19))
                    0, 1:    add_deep_file();
                    2, 3, 4: add_noise_file();
                    default: add_wellformed_file();
                endcase
            end
            while (src_bytes.size() != 0 || s_tvalid || verdicts_due.size() != 0)
                @(negedge aclk);
        end

        repeat (10) @(negedge aclk);
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("c_bracket_quote_comment_checker_core: match");
        end else begin
            $display("c_bracket_quote_comment_checker_core: mismatch");
        end
        $finish;
    end

endmodule
